### rtl/core/tsvfi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvfi_pkg
// Shared widths, byte codes and the run descriptor passed from the scanner
// to the entry emitter of the tab-separated field indexer.
// ----------------------------------------------------------------------------
package tsvfi_pkg;

	// fixed widths of the channel fields
	localparam int BYTE_W = 8;
	localparam int ROW_W = 16;
	localparam int COL_W = 6;
	localparam int POS_W = 24;
	// run column width, wide enough for a column count of 64
	localparam int RUN_COL_W = 7;

	// delimiter codes
	localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] CH_CR = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF = 8'h0a;

	// one run of entries over consecutive columns first_col..last_col;
	// the first entry carries the field, the rest are zero-length padding
	typedef struct packed {
		logic [ROW_W-1:0]     row;
		logic [RUN_COL_W-1:0] first_col;
		logic [RUN_COL_W-1:0] last_col;
		logic [POS_W-1:0]     first_offset;
		logic [POS_W-1:0]     first_length;
		logic [POS_W-1:0]     pad_offset;
		logic                 final_run;
	} run_t;

endpackage

### rtl/core/tsvfi_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvfi channel interfaces
// Valid/ready channels for table text bytes and for field index entries.
// ----------------------------------------------------------------------------
interface tsvfi_byte_if;
	logic                         valid;
	logic                         ready;
	logic [tsvfi_pkg::BYTE_W-1:0] data_byte;
	logic                         final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

interface tsvfi_entry_if;
	logic                        valid;
	logic                        ready;
	logic [tsvfi_pkg::ROW_W-1:0] row_index;
	logic [tsvfi_pkg::COL_W-1:0] column_index;
	logic [tsvfi_pkg::POS_W-1:0] field_offset;
	logic [tsvfi_pkg::POS_W-1:0] field_length;
	logic                        last_of_run;
	logic                        table_end;

	modport source (output valid, output row_index, output column_index,
		output field_offset, output field_length, output last_of_run,
		output table_end, input ready);
	modport sink (input valid, input row_index, input column_index,
		input field_offset, input field_length, input last_of_run,
		input table_end, output ready);
endinterface

### rtl/core/tsvfi_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvfi_scan
// Byte scanner: tracks position, field start, column, row and line state,
// and turns each accepted byte into at most one run of entries.
// ----------------------------------------------------------------------------
module tsvfi_scan #(
	parameter int MAX_COLUMNS = 64,
	parameter int POSITION_BITS = 24,
	parameter int ROW_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [tsvfi_pkg::BYTE_W-1:0] data_byte,
	input  logic                         final_byte,
	output logic                         run_valid,
	output tsvfi_pkg::run_t              run
);
	import tsvfi_pkg::*;

	localparam int COL_BITS = $clog2(MAX_COLUMNS + 1);
	localparam logic [COL_BITS-1:0] COL_MAX = COL_BITS'(MAX_COLUMNS);

	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [COL_BITS-1:0]      cur_q;
	logic [COL_BITS-1:0]      cnt_q;
	logic [ROW_BITS-1:0]      row_q;
	logic                     first_q;
	logic                     after_cr_q;

	logic [POSITION_BITS-1:0] nxt;
	logic [POSITION_BITS-1:0] end_pos;
	logic [POSITION_BITS-1:0] len;
	logic [COL_BITS-1:0]      lim;
	logic [COL_BITS-1:0]      lim_m1;
	logic [COL_BITS:0]        cur_wide;
	logic [COL_BITS-1:0]      cnt_new;
	logic [COL_BITS-1:0]      last_col;
	logic                     is_tab;
	logic                     is_eol;
	logic                     swallow;
	logic                     closes;

	// byte classification and column limit
	assign is_tab = (data_byte == CH_TAB);
	assign is_eol = (data_byte == CH_CR) || (data_byte == CH_LF);
	assign swallow = after_cr_q && (data_byte == CH_LF);
	assign closes = is_eol || (final_byte && !is_tab);
	assign nxt = pos_q + 1'b1;
	assign lim = first_q ? COL_MAX : cnt_q;
	assign lim_m1 = lim - 1'b1;
	assign cur_wide = {1'b0, cur_q} + 1'b1;
	assign cnt_new = (cur_wide > {1'b0, COL_MAX}) ? COL_MAX : cur_wide[COL_BITS-1:0];

	// first field length: tab and line breaks end before the byte, final byte after
	assign end_pos = (is_tab || is_eol) ? pos_q : nxt;
	assign len = end_pos - start_q;

	// last column of the run
	always_comb begin
		if (is_tab && !final_byte) begin
			last_col = cur_q;
		end else if (first_q) begin
			if (is_tab && (cur_wide < {1'b0, lim}))
				last_col = cur_wide[COL_BITS-1:0];
			else if (is_tab)
				last_col = lim_m1;
			else
				last_col = cur_q;
		end else begin
			last_col = lim_m1;
		end
	end

	// run descriptor
	assign run_valid = accept && !swallow && (is_tab || is_eol || final_byte) && (cur_q < lim);
	assign run.row = ROW_W'(row_q);
	assign run.first_col = RUN_COL_W'(cur_q);
	assign run.last_col = RUN_COL_W'(last_col);
	assign run.first_offset = POS_W'(start_q);
	assign run.first_length = POS_W'(len);
	assign run.pad_offset = POS_W'(nxt);
	assign run.final_run = final_byte;

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			start_q <= '0;
			cur_q <= '0;
			cnt_q <= '0;
			row_q <= '0;
			first_q <= 1'b1;
			after_cr_q <= 1'b0;
		end else if (accept) begin
			if (final_byte) begin
				pos_q <= '0;
				start_q <= '0;
				cur_q <= '0;
				cnt_q <= '0;
				row_q <= '0;
				first_q <= 1'b1;
				after_cr_q <= 1'b0;
			end else if (swallow) begin
				pos_q <= nxt;
				start_q <= nxt;
				after_cr_q <= 1'b0;
			end else begin
				pos_q <= nxt;
				after_cr_q <= (data_byte == CH_CR);
				if (is_tab) begin
					start_q <= nxt;
					if (cur_q < COL_MAX)
						cur_q <= cur_wide[COL_BITS-1:0];
				end else if (closes) begin
					start_q <= nxt;
					cur_q <= '0;
					row_q <= row_q + 1'b1;
					first_q <= 1'b0;
					if (first_q)
						cnt_q <= cnt_new;
				end
			end
		end
	end

endmodule

### rtl/core/tsvfi_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvfi_emit
// Entry emitter: holds one run and presents its entries one per cycle, while
// entry is ready, the field first and then the zero-length padding columns.
// ----------------------------------------------------------------------------
module tsvfi_emit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  tsvfi_pkg::run_t      run,
	output logic                 can_load,
	tsvfi_entry_if.source        entry
);
	import tsvfi_pkg::*;

	logic                 busy_q;
	logic [ROW_W-1:0]     row_q;
	logic [RUN_COL_W-1:0] col_q;
	logic [RUN_COL_W-1:0] last_q;
	logic [POS_W-1:0]     off_q;
	logic [POS_W-1:0]     len_q;
	logic [POS_W-1:0]     pad_q;
	logic                 fin_q;
	logic                 is_last;

	// a new run may load when the held one is gone or leaves this cycle
	assign is_last = (col_q == last_q);
	assign can_load = !busy_q || (is_last && entry.ready);

	// entry output
	assign entry.valid = busy_q;
	assign entry.row_index = row_q;
	assign entry.column_index = col_q[COL_W-1:0];
	assign entry.field_offset = off_q;
	assign entry.field_length = len_q;
	assign entry.last_of_run = is_last;
	assign entry.table_end = is_last && fin_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (busy_q && entry.ready && is_last) begin
			busy_q <= 1'b0;
		end
	end

	// run payload, stepping to the next padding column per transaction
	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= run.row;
			col_q <= run.first_col;
			last_q <= run.last_col;
			off_q <= run.first_offset;
			len_q <= run.first_length;
			pad_q <= run.pad_offset;
			fin_q <= run.final_run;
		end else if (busy_q && entry.ready && !is_last) begin
			col_q <= col_q + 1'b1;
			off_q <= pad_q;
			len_q <= '0;
		end
	end

endmodule

### rtl/core/tsv_field_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsv_field_indexer
// Splits a tab-separated table, one byte per transaction, into field index
// entries (row, column, offset, length), padding short lines to the column
// count set by the first line and dropping extra fields.
//
// channel  role  payload
// text     sink  data_byte[7:0], final_byte
// entry    src   row_index[15:0], column_index[5:0], field_offset[23:0],
//                field_length[23:0], last_of_run, table_end
//
// One byte is taken per cycle while text.ready is high; its entries appear
// in the cycle after the byte is taken. A byte that yields a run of n entries
// holds text.ready low while the emitter steps through the padding columns,
// and also while entry stalls, the last entry of a run included.
// arst_n clears all line and position state; a final byte restarts at zero.
// ----------------------------------------------------------------------------
module tsv_field_indexer #(
	parameter int MAX_COLUMNS = 64,
	parameter int POSITION_BITS = 24,
	parameter int ROW_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	tsvfi_byte_if.sink    text,
	tsvfi_entry_if.source entry
);
	import tsvfi_pkg::*;

	logic accept;
	logic can_load;
	logic run_valid;
	run_t run;

	// input handshake
	assign text.ready = can_load;
	assign accept = text.valid && can_load;

	// byte scanner
	tsvfi_scan #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.POSITION_BITS(POSITION_BITS),
		.ROW_BITS(ROW_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.data_byte(text.data_byte),
		.final_byte(text.final_byte),
		.run_valid(run_valid),
		.run(run)
	);

	// entry emitter
	tsvfi_emit u_emit (
		.clk(clk),
		.arst_n(arst_n),
		.load(run_valid),
		.run(run),
		.can_load(can_load),
		.entry(entry)
	);

`ifndef SYNTH
	// emitted column stays within the configured column limit
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry.valid |-> (32'(entry.column_index) < MAX_COLUMNS))
		else $error("column index beyond limit");

	// end of table is only flagged on the last entry of a run
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(entry.valid && entry.table_end) |-> entry.last_of_run)
		else $error("table end not on last entry of run");

	// input is only taken when no unfinished run would be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		text.ready |-> (!entry.valid || (entry.last_of_run && entry.ready)))
		else $error("input ready while run still pending");

	// a run continues with the next column right after a non-final transaction
	a_run_step: assert property (@(posedge clk) disable iff (!arst_n)
		(entry.valid && entry.ready && !entry.last_of_run) |=>
		(entry.valid && (entry.column_index == 6'($past(entry.column_index) + 1'b1))))
		else $error("run did not advance to next column");
`endif

endmodule

### sim/tsvfi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsvfi_checker
// Watches the text and entry channels of the field indexer, keeps its own
// line and column state to predict the entries of every accepted byte, and
// compares each accepted entry with the oldest prediction.
// ----------------------------------------------------------------------------
module tsvfi_checker #(
	parameter int MAX_COLUMNS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	tsvfi_byte_if  text,
	tsvfi_entry_if entry,
	output int     errors,
	output int     pending,
	output int     checked
);
	import tsvfi_pkg::*;

	// one predicted field entry
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] column;
		logic [POS_W-1:0] offset;
		logic [POS_W-1:0] length;
		logic             run_last;
		logic             table_last;
	} index_entry_t;

	index_entry_t expected_q[$];
	index_entry_t run_q[$];
	index_entry_t want;

	// scanner state
	logic [POS_W-1:0] scan_pos;
	logic [POS_W-1:0] field_begin;
	int unsigned      col_now;
	int unsigned      col_total;
	logic [ROW_W-1:0] row_now;
	bit               header_line;
	bit               saw_cr;

	int fail_total;
	int checked_total;

	task automatic report_mismatch(input string what);
		fail_total++;
		$display("[%0t] entry %0d mismatch: %s", $time, checked_total, what);
	endtask

	function automatic void clear_scan();
		scan_pos = '0;
		field_begin = '0;
		col_now = 0;
		col_total = 0;
		row_now = '0;
		header_line = 1'b1;
		saw_cr = 1'b0;
	endfunction

	function automatic int unsigned column_limit();
		return header_line ? MAX_COLUMNS : col_total;
	endfunction

	function automatic void emit_field(input int unsigned col, input logic [POS_W-1:0] off,
			input logic [POS_W-1:0] len);
		index_entry_t e;
		e.row = row_now;
		e.column = col[COL_W-1:0];
		e.offset = off;
		e.length = len;
		e.run_last = 1'b0;
		e.table_last = 1'b0;
		run_q.push_back(e);
	endfunction

	// finish the open field at stop, pad or size the line, restart at resume
	function automatic void end_line(input logic [POS_W-1:0] stop,
			input logic [POS_W-1:0] resume);
		int unsigned c;
		if (col_now < column_limit())
			emit_field(col_now, field_begin, stop - field_begin);
		if (header_line) begin
			col_total = (col_now + 1 > MAX_COLUMNS) ? MAX_COLUMNS : col_now + 1;
		end else begin
			for (c = col_now + 1; c < col_total; c++)
				emit_field(c, resume, '0);
		end
		row_now++;
		col_now = 0;
		header_line = 1'b0;
		field_begin = resume;
	endfunction

	// entries caused by one text byte, appended to the expected store
	function automatic void predict_byte(input logic [BYTE_W-1:0] b, input logic fin);
		logic [POS_W-1:0] here;
		logic [POS_W-1:0] nxt;
		here = scan_pos;
		nxt = scan_pos + 1'b1;
		run_q.delete();

		// lf right after cr only moves the field start
		if (saw_cr && b == CH_LF) begin
			saw_cr = 1'b0;
			field_begin = nxt;
			scan_pos = nxt;
			if (fin)
				clear_scan();
			return;
		end
		saw_cr = 1'b0;

		if (b == CH_TAB) begin
			if (col_now < column_limit())
				emit_field(col_now, field_begin, here - field_begin);
			if (col_now < MAX_COLUMNS)
				col_now++;
			field_begin = nxt;
			if (fin)
				end_line(nxt, nxt);
		end else if (b == CH_CR || b == CH_LF) begin
			end_line(here, nxt);
			saw_cr = (b == CH_CR);
		end else if (fin) begin
			end_line(nxt, nxt);
		end

		if (run_q.size() > 0) begin
			run_q[run_q.size() - 1].run_last = 1'b1;
			if (fin)
				run_q[run_q.size() - 1].table_last = 1'b1;
		end
		foreach (run_q[i])
			expected_q.push_back(run_q[i]);

		if (fin)
			clear_scan();
		else
			scan_pos = nxt;
	endfunction

	// predict on text transactions, compare on entry transactions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scan();
			expected_q.delete();
		end else begin
			if (text.valid && text.ready)
				predict_byte(text.data_byte, text.final_byte);
			if (entry.valid && entry.ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch($sformatf("no entry pending, got row %0d col %0d",
						entry.row_index, entry.column_index));
				end else begin
					want = expected_q.pop_front();
					if (entry.row_index !== want.row)
						report_mismatch($sformatf("row_index %0d, expected %0d",
							entry.row_index, want.row));
					if (entry.column_index !== want.column)
						report_mismatch($sformatf("column_index %0d, expected %0d",
							entry.column_index, want.column));
					if (entry.field_offset !== want.offset)
						report_mismatch($sformatf("field_offset %0d, expected %0d",
							entry.field_offset, want.offset));
					if (entry.field_length !== want.length)
						report_mismatch($sformatf("field_length %0d, expected %0d",
							entry.field_length, want.length));
					if (entry.last_of_run !== want.run_last)
						report_mismatch($sformatf("last_of_run %b, expected %b",
							entry.last_of_run, want.run_last));
					if (entry.table_end !== want.table_last)
						report_mismatch($sformatf("table_end %b, expected %b",
							entry.table_end, want.table_last));
				end
				checked_total++;
			end
		end
	end

	// counts handed to the top
	always @(posedge clk) begin
		errors <= fail_total;
		pending <= expected_q.size();
		checked <= checked_total;
	end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the field indexer with a short directed set of tables and then with
// random tables and byte noise, with random idle gaps on the text side and
// random stalls plus two long hold-offs on the entry side; the checker
// beside the block predicts and compares every entry.
// ----------------------------------------------------------------------------
module tb_top;
	import tsvfi_pkg::*;

	localparam int MAX_COLUMNS = 64;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n;

	tsvfi_byte_if  text_ch ();
	tsvfi_entry_if entry_ch ();

	int errors;
	int pending;
	int checked;

	int cycle_count = 0;
	int sent_bytes = 0;
	int tables_sent = 0;
	int noise_bursts = 0;
	int widest_header = 0;
	bit quiet_send = 1'b0;

	tsv_field_indexer #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.POSITION_BITS(POS_W),
		.ROW_BITS(ROW_W)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.entry(entry_ch)
	);

	tsvfi_checker #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) index_check (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.entry(entry_ch),
		.errors(errors),
		.pending(pending),
		.checked(checked)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d entries pending",
				cycle_count, pending);
			$display("FAILURE");
			$finish;
		end
	end

	// one text transaction after a random idle gap
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int unsigned gap;
		gap = quiet_send ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid <= 1'b1;
		text_ch.data_byte <= b;
		text_ch.final_byte <= fin;
		@(posedge clk);
		while (!text_ch.ready)
			@(posedge clk);
		sent_bytes++;
	endtask

	// any byte that is not a delimiter
	function automatic logic [BYTE_W-1:0] field_char();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(0, 255));
		while (c == CH_TAB || c == CH_CR || c == CH_LF)
			c = BYTE_W'($urandom_range(0, 255));
		return c;
	endfunction

	// well-formed table: header of width fields, ragged later lines
	task automatic send_table(input int unsigned width);
		logic [BYTE_W-1:0] text_q[$];
		int unsigned lines;
		int unsigned fields;
		int unsigned flen;
		int unsigned ending;
		lines = (width > 8) ? $urandom_range(1, 3) : $urandom_range(1, 6);
		ending = $urandom_range(0, 2);
		for (int unsigned l = 0; l < lines; l++) begin
			if (l == 0 || $urandom_range(0, 2) == 0)
				fields = width;
			else
				fields = $urandom_range(1, width + 2);
			for (int unsigned f = 0; f < fields; f++) begin
				if (f > 0)
					text_q.push_back(CH_TAB);
				if (width > 8)
					flen = $urandom_range(0, 1);
				else
					flen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
				repeat (flen) text_q.push_back(field_char());
			end
			// last line may stay open or end on a tab
			if (l + 1 < lines || ending == 0) begin
				case ($urandom_range(0, 2))
					0: text_q.push_back(CH_CR);
					1: text_q.push_back(CH_LF);
					default: begin
						text_q.push_back(CH_CR);
						text_q.push_back(CH_LF);
					end
				endcase
			end
		end
		if (ending == 2)
			text_q.push_back(CH_TAB);
		if (text_q.size() == 0)
			text_q.push_back(field_char());
		foreach (text_q[i])
			send_byte(text_q[i], i == text_q.size() - 1);
		tables_sent++;
		if (width > widest_header)
			widest_header = width;
	endtask

	// random bytes heavy in delimiters, closed by a final byte
	task automatic send_noise();
		int unsigned n;
		logic [BYTE_W-1:0] b;
		n = $urandom_range(4, 16);
		for (int unsigned i = 0; i < n; i++) begin
			case ($urandom_range(0, 7))
				0, 1: b = CH_TAB;
				2: b = CH_CR;
				3: b = CH_LF;
				default: b = BYTE_W'($urandom_range(0, 255));
			endcase
			send_byte(b, (i == n - 1) || ($urandom_range(0, 15) == 0));
		end
		noise_bursts++;
	endtask

	// entry side: random stalls, quiet stretches and two long hold-offs
	initial begin
		int unsigned stall;
		int taken;
		bit quiet_recv;
		taken = 0;
		quiet_recv = 1'b0;
		entry_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (taken == 60 || taken == 400) begin
				entry_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (taken % 40 == 0)
				quiet_recv = ($urandom_range(0, 3) == 0);
			stall = quiet_recv ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				entry_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			entry_ch.ready <= 1'b1;
			@(posedge clk);
			while (!entry_ch.valid)
				@(posedge clk);
			taken++;
		end
	end

	// text side stimulus and verdict
	initial begin
		arst_n <= 1'b0;
		text_ch.valid <= 1'b0;
		text_ch.data_byte <= '0;
		text_ch.final_byte <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// header with an empty middle field, cr lf ending
		send_byte("a", 1'b0);
		send_byte("b", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte("c", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b0);
		// short line gets padded
		send_byte("x", 1'b0);
		send_byte(CH_LF, 1'b0);
		// extra fields dropped, then a swallowed lf as the final byte
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_CR, 1'b0);
		send_byte(CH_LF, 1'b1);
		// tab as the final byte of a one-line table
		send_byte(8'hff, 1'b0);
		send_byte(CH_TAB, 1'b1);
		// final byte that only ends a dropped extra field
		send_byte(8'h00, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_byte("a", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte("b", 1'b1);

		// header wider than the column limit
		send_table(66);
		while (sent_bytes < 420) begin
			quiet_send = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) == 0)
				send_noise();
			else if ($urandom_range(0, 15) == 0)
				send_table($urandom_range(60, 70));
			else
				send_table($urandom_range(1, 6));
		end
		text_ch.valid <= 1'b0;

		// let the pending count catch up with the last text transaction
		repeat (2) @(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("sent %0d text bytes: %0d tables (widest header %0d fields), %0d noise bursts",
			sent_bytes, tables_sent, widest_header, noise_bursts);
		$display("compared %0d field entries in %0d cycles", checked, cycle_count);
		if (errors == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
